>>> sv/mdpd_pkg.sv
package mdpd_pkg;

    localparam int BODY_DEPTH_DEF = 64;
    localparam int MARKER_MAX_DEF = 4;

    localparam int BYTE_W       = 8;
    localparam int MATCH_W      = 3;
    localparam int MARKER_BYTES = 4;
    localparam int LEN_OUT_W    = 6;
    localparam int STATUS_W     = 2;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 32;
    localparam int SEQ_W        = MARKER_BYTES * BYTE_W;
    localparam int M_TDATA_W    = 16;

    typedef enum logic [STATUS_W-1:0] {
        FS_PAYLOAD  = 2'd0,
        FS_EMPTY    = 2'd1,
        FS_OVERFLOW = 2'd2
    } frame_status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HEADER_BYTES  = 2'd0,
        REG_HEADER_LEN    = 2'd1,
        REG_TRAILER_BYTES = 2'd2,
        REG_TRAILER_LEN   = 2'd3
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_STATUS,
        ST_READ,
        ST_LOAD
    } state_t;

    typedef struct packed {
        logic [MATCH_W-1:0] count;
        logic [MATCH_W-1:0] eff_len;
        logic               done;
    } match_res_t;

endpackage

>>> sv/mdpd_ram.sv
module mdpd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> sv/mdpd_match.sv
module mdpd_match
    import mdpd_pkg::*;
#(
    parameter int MARKER_MAX = MARKER_MAX_DEF
) (
    input  logic [BYTE_W-1:0]  rx_byte,
    input  logic [SEQ_W-1:0]   seq,
    input  logic [MATCH_W-1:0] len,
    input  logic [MATCH_W-1:0] count,
    output match_res_t         res
);

    logic [MATCH_W-1:0] eff;
    logic [BYTE_W-1:0]  expected;
    logic [1:0]         sel;
    logic [MATCH_W-1:0] nxt;

    assign sel = count[1:0];

    always_comb begin
        eff = len;
        if (len == '0) begin
            eff = MATCH_W'(1);
        end else if (int'(len) > MARKER_MAX) begin
            eff = MATCH_W'(MARKER_MAX);
        end

        // Marker positions past the register's bytes compare against zero.
        if (int'(count) >= MARKER_BYTES) begin
            expected = '0;
        end else begin
            expected = seq[sel*BYTE_W +: BYTE_W];
        end

        if (count < eff && rx_byte == expected) begin
            nxt = count + 1'b1;
        end else begin
            nxt = '0;
        end

        res.count   = nxt;
        res.eff_len = eff;
        res.done    = (nxt >= eff);
    end

endmodule

>>> sv/marker_delimited_packet_deframer.sv
// Each input byte is accepted in ST_IDLE and checked in ST_CHECK by the shared marker
// comparator, during which s_tready is low. The first payload byte is read in ST_READ
// and loaded in ST_LOAD after the ST_CHECK that ends the marker; later bytes repeat both,
// ST_LOAD waiting for a free output register. Empty and overflow results leave through
// ST_STATUS. Reset (aresetn low, synchronous) restores the register defaults, resumes
// the header hunt and clears the output valid; the body store is not cleared.
module marker_delimited_packet_deframer
    import mdpd_pkg::*;
#(
    parameter int BODY_DEPTH = BODY_DEPTH_DEF,
    parameter int MARKER_MAX = MARKER_MAX_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [BYTE_W-1:0]     s_tdata,    // [7:0] rx_byte

    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,    // [7:0] payload_byte, [13:8] payload_length
    output logic                  m_tlast,
    output logic [STATUS_W-1:0]   m_tuser,    // [1:0] frame_status

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int CNT_W   = $clog2(BODY_DEPTH + 1);
    localparam int ADDR_W  = $clog2(BODY_DEPTH);
    localparam int LEN_MAX = 2 ** LEN_OUT_W - 1;

    logic [SEQ_W-1:0]   hdr_bytes_reg;
    logic [MATCH_W-1:0] hdr_len_reg;
    logic [SEQ_W-1:0]   trl_bytes_reg;
    logic [MATCH_W-1:0] trl_len_reg;

    state_t             state_reg, state_next;
    logic [BYTE_W-1:0]  byte_reg;
    logic               in_body_reg, in_body_next;
    logic [MATCH_W-1:0] hdr_cnt_reg, hdr_cnt_next;
    logic [MATCH_W-1:0] trl_cnt_reg, trl_cnt_next;
    logic [CNT_W-1:0]   body_cnt_reg, body_cnt_next;
    logic [CNT_W-1:0]   plen_reg, plen_next;
    logic [ADDR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    frame_status_t      status_reg, status_next;

    logic               m_valid_reg, m_valid_next;
    logic [BYTE_W-1:0]  m_byte_reg, m_byte_next;
    logic [LEN_OUT_W-1:0] m_len_reg, m_len_next;
    logic               m_last_reg, m_last_next;
    frame_status_t      m_status_reg, m_status_next;

    logic [SEQ_W-1:0]   mt_seq;
    logic [MATCH_W-1:0] mt_len;
    logic [MATCH_W-1:0] mt_count;
    match_res_t         mt_res;

    logic               ram_we;
    logic [BYTE_W-1:0]  ram_rdata;

    logic               overflow;
    logic [CNT_W-1:0]   bc_inc;
    logic [CNT_W-1:0]   tl_ext;
    logic [CNT_W-1:0]   plen_calc;
    logic               out_free;
    logic               rd_last;

    // One comparator serves the header hunt and the end marker search.
    assign mt_seq   = in_body_reg ? trl_bytes_reg : hdr_bytes_reg;
    assign mt_len   = in_body_reg ? trl_len_reg   : hdr_len_reg;
    assign mt_count = in_body_reg ? trl_cnt_reg   : hdr_cnt_reg;

    mdpd_match #(
        .MARKER_MAX(MARKER_MAX)
    ) u_match (
        .rx_byte(byte_reg),
        .seq    (mt_seq),
        .len    (mt_len),
        .count  (mt_count),
        .res    (mt_res)
    );

    mdpd_ram #(
        .WIDTH(BYTE_W),
        .DEPTH(BODY_DEPTH)
    ) u_body_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(body_cnt_reg[ADDR_W-1:0]),
        .wdata(byte_reg),
        .raddr(rd_ptr_reg),
        .rdata(ram_rdata)
    );

    assign overflow  = (body_cnt_reg == CNT_W'(BODY_DEPTH));
    assign bc_inc    = body_cnt_reg + 1'b1;
    assign tl_ext    = CNT_W'(mt_res.eff_len);
    assign plen_calc = (bc_inc > tl_ext) ? (bc_inc - tl_ext) : '0;
    assign out_free  = !m_valid_reg || m_tready;
    assign rd_last   = ((CNT_W'(rd_ptr_reg) + 1'b1) == plen_reg);
    assign ram_we    = (state_reg == ST_CHECK) && in_body_reg && !overflow;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = M_TDATA_W'({m_len_reg, m_byte_reg});
    assign m_tlast   = m_last_reg;
    assign m_tuser   = m_status_reg;

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                state_next = ST_IDLE;
                if (in_body_reg) begin
                    if (overflow) begin
                        state_next = ST_STATUS;
                    end else if (mt_res.done) begin
                        state_next = (plen_calc == '0) ? ST_STATUS : ST_READ;
                    end
                end
            end
            ST_STATUS: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_READ: begin
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                if (out_free) begin
                    state_next = rd_last ? ST_IDLE : ST_READ;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and output register.
    always_comb begin
        in_body_next  = in_body_reg;
        hdr_cnt_next  = hdr_cnt_reg;
        trl_cnt_next  = trl_cnt_reg;
        body_cnt_next = body_cnt_reg;
        plen_next     = plen_reg;
        rd_ptr_next   = rd_ptr_reg;
        status_next   = status_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_byte_next   = m_byte_reg;
        m_len_next    = m_len_reg;
        m_last_next   = m_last_reg;
        m_status_next = m_status_reg;

        unique case (state_reg)
            ST_CHECK: begin
                if (!in_body_reg) begin
                    hdr_cnt_next = mt_res.done ? '0 : mt_res.count;
                    if (mt_res.done) begin
                        in_body_next  = 1'b1;
                        trl_cnt_next  = '0;
                        body_cnt_next = '0;
                    end
                end else if (overflow) begin
                    in_body_next  = 1'b0;
                    hdr_cnt_next  = '0;
                    trl_cnt_next  = '0;
                    body_cnt_next = '0;
                    status_next   = FS_OVERFLOW;
                end else if (mt_res.done) begin
                    in_body_next  = 1'b0;
                    hdr_cnt_next  = '0;
                    trl_cnt_next  = '0;
                    body_cnt_next = '0;
                    plen_next     = plen_calc;
                    rd_ptr_next   = '0;
                    status_next   = FS_EMPTY;
                end else begin
                    trl_cnt_next  = mt_res.count;
                    body_cnt_next = bc_inc;
                end
            end
            ST_STATUS: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_byte_next   = '0;
                    m_len_next    = '0;
                    m_last_next   = 1'b1;
                    m_status_next = status_reg;
                end
            end
            ST_LOAD: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_byte_next   = ram_rdata;
                    m_len_next    = (int'(plen_reg) > LEN_MAX) ? LEN_OUT_W'(LEN_MAX)
                                                               : LEN_OUT_W'(plen_reg);
                    m_last_next   = rd_last;
                    m_status_next = FS_PAYLOAD;
                    rd_ptr_next   = rd_ptr_reg + 1'b1;
                end
            end
            ST_IDLE, ST_READ: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hdr_bytes_reg <= '0;
            hdr_len_reg   <= MATCH_W'(1);
            trl_bytes_reg <= '0;
            trl_len_reg   <= MATCH_W'(1);
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_HEADER_BYTES:  hdr_bytes_reg <= cfg_data[SEQ_W-1:0];
                REG_HEADER_LEN:    hdr_len_reg   <= cfg_data[MATCH_W-1:0];
                REG_TRAILER_BYTES: trl_bytes_reg <= cfg_data[SEQ_W-1:0];
                REG_TRAILER_LEN:   trl_len_reg   <= cfg_data[MATCH_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            in_body_reg  <= 1'b0;
            hdr_cnt_reg  <= '0;
            trl_cnt_reg  <= '0;
            body_cnt_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            in_body_reg  <= in_body_next;
            hdr_cnt_reg  <= hdr_cnt_next;
            trl_cnt_reg  <= trl_cnt_next;
            body_cnt_reg <= body_cnt_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            byte_reg <= s_tdata;
        end
        plen_reg     <= plen_next;
        rd_ptr_reg   <= rd_ptr_next;
        status_reg   <= status_next;
        m_byte_reg   <= m_byte_next;
        m_len_reg    <= m_len_next;
        m_last_reg   <= m_last_next;
        m_status_reg <= m_status_next;
    end

endmodule
